>>> design/stnl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table nearest lookup package
// Shared types and codes for the sorted point table and its cells.
// ----------------------------------------------------------------------------
package stnl_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned CntW = 9;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_LIMITS    = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_ENABLE = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_REDUCE,
    S_RESP
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                   shift;  // insert: cells above the slot move right
    logic signed [ValW-1:0] px;
    logic signed [ValW-1:0] py;
  } cell_ctl_t;

endpackage

>>> design/stnl_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel interfaces
// Input and result channels of the sorted table nearest lookup.
// ----------------------------------------------------------------------------
interface stnl_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;
  modport source (output valid, operation, point_x, point_y, query_x, input ready);
  modport sink   (input valid, operation, point_x, point_y, query_x, output ready);
endinterface

interface stnl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_y;
  logic [2:0]         status;
  logic [8:0]         point_count;
  modport source (output valid, value_y, status, point_count, input ready);
  modport sink   (input valid, value_y, status, point_count, output ready);
endinterface

>>> design/stnl_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one point; on insert either keeps it, takes the new point or takes
// the left neighbour's point.
// ----------------------------------------------------------------------------
module stnl_cell
  import stnl_pkg::*;
(
  input  logic                   clk_i,
  input  cell_ctl_t              ctl_i,
  input  logic                   below_i,  // this cell's index is below the slot
  input  logic                   is_slot_i,
  input  logic signed [ValW-1:0] left_x_i,
  input  logic signed [ValW-1:0] left_y_i,
  output logic signed [ValW-1:0] x_o,
  output logic signed [ValW-1:0] y_o
);

  logic signed [ValW-1:0] x_q, x_d, y_q, y_d;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (ctl_i.shift && !below_i) begin
      if (is_slot_i) begin
        x_d = ctl_i.px;
        y_d = ctl_i.py;
      end else begin
        x_d = left_x_i;
        y_d = left_y_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

>>> design/sorted_table_nearest_lookup.sv
// ----------------------------------------------------------------------------
// Sorted table nearest lookup
// Stepwise interpolation table held in a row of sorted point cells.
// ----------------------------------------------------------------------------
// A transaction is taken only in the idle state and then passes the evaluate
// and reduce states: in the evaluate state the key or new point is broadcast
// and every cell registers its compare flags; in the reduce state the flags,
// which form thermometer codes over the sorted row, are turned into one-hot
// slot and neighbour selects, the result is formed and an insert shifts the
// upper cells one place. The result is offered in the response state and the
// next transaction is taken in the cycle after the result has been handed
// over; a stalled result holds the block in the response state.
module sorted_table_nearest_lookup
  import stnl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  stnl_in_if.sink           in_if,
  stnl_out_if.source        out_if
);

  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  logic signed [ValW-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic [3:0]             en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlo_q <= {1'b1, {(ValW-1){1'b0}}};
      xhi_q <= {1'b0, {(ValW-1){1'b1}}};
      ylo_q <= {1'b1, {(ValW-1){1'b0}}};
      yhi_q <= {1'b0, {(ValW-1){1'b1}}};
      en_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_X_LOW:  xlo_q <= cfg_data_i;
        REG_X_HIGH: xhi_q <= cfg_data_i;
        REG_Y_LOW:  ylo_q <= cfg_data_i;
        REG_Y_HIGH: yhi_q <= cfg_data_i;
        REG_ENABLE: en_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [1:0]             op_q;
  logic signed [ValW-1:0] px_q, py_q, qx_q;
  logic [NW-1:0]          n_q, n_d;
  logic signed [ValW-1:0] val_q, val_d;
  status_e                st_q, st_d;

  logic signed [ValW-1:0] cx [TABLE_DEPTH];
  logic signed [ValW-1:0] cy [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid, lt_d, eq_d, le_d;
  logic [TABLE_DEPTH-1:0] lt_q, eq_q, le_q;
  cell_ctl_t              ctl;

  // Per-cell compare of the broadcast values, registered at the end of the
  // evaluation cycle.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      valid[i] = (NW'(i) < n_q);
      lt_d[i]  = valid[i] && (cx[i] < px_q);
      eq_d[i]  = valid[i] && (cx[i] == px_q);
      le_d[i]  = valid[i] && (cx[i] <= qx_q);
    end
  end

  // The row is sorted, so the flags are thermometer codes and each boundary
  // is found by comparing a cell's flag with its neighbour's.
  logic [TABLE_DEPTH-1:0] lt_prev, le_prev, slot_oh, left_oh, right_oh;
  always_comb begin
    lt_prev  = TABLE_DEPTH'({lt_q, 1'b1});
    le_prev  = TABLE_DEPTH'({le_q, 1'b1});
    slot_oh  = ~lt_q & lt_prev;
    left_oh  = le_q & ~(le_q >> 1);
    right_oh = valid & ~le_q & le_prev;
  end

  logic lim_bad, dup, full;
  always_comb begin
    lim_bad = (en_q[0] && px_q < xlo_q) || (en_q[1] && px_q > xhi_q) ||
              (en_q[2] && py_q < ylo_q) || (en_q[3] && py_q > yhi_q);
    dup  = |(slot_oh & eq_q);
    full = (n_q >= NW'(TABLE_DEPTH));
  end

  logic signed [ValW-1:0] xl, yl, xr, yr;
  logic signed [ValW:0]   dl, dr;
  logic signed [ValW-1:0] qval;
  always_comb begin
    xl = '0;
    yl = '0;
    xr = '0;
    yr = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      xl = xl | (cx[i] & {ValW{left_oh[i]}});
      yl = yl | (cy[i] & {ValW{left_oh[i]}});
      xr = xr | (cx[i] & {ValW{right_oh[i]}});
      yr = yr | (cy[i] & {ValW{right_oh[i]}});
    end
    dl = {qx_q[ValW-1], qx_q} - {xl[ValW-1], xl};
    dr = {xr[ValW-1], xr} - {qx_q[ValW-1], qx_q};
    if (!le_q[0])              qval = cy[0];
    else if (right_oh == '0)   qval = yl;
    else if (dl < dr)          qval = yl;
    else                       qval = yr;
  end

  always_comb begin
    ctl.px    = px_q;
    ctl.py    = py_q;
    ctl.shift = 1'b0;
    n_d   = n_q;
    val_d = val_q;
    st_d  = st_q;
    if (state_q == S_REDUCE) begin
      val_d = '0;
      st_d  = ST_OK;
      case (op_e'(op_q))
        OP_CLEAR: n_d = '0;
        OP_INSERT: begin
          if (lim_bad)   st_d = ST_LIMITS;
          else if (dup)  st_d = ST_DUPLICATE;
          else if (full) st_d = ST_FULL;
          else begin
            st_d = ST_INSERTED;
            ctl.shift = 1'b1;
            n_d = n_q + NW'(1);
          end
        end
        OP_QUERY: begin
          if (n_q == '0) st_d = ST_EMPTY;
          else val_d = qval;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic signed [ValW-1:0] lx, ly;
    if (g == 0) begin : g_first
      assign lx = px_q;
      assign ly = py_q;
    end else begin : g_rest
      assign lx = cx[g-1];
      assign ly = cy[g-1];
    end
    stnl_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .below_i   (lt_q[g]),
      .is_slot_i (slot_oh[g]),
      .left_x_i  (lx),
      .left_y_i  (ly),
      .x_o       (cx[g]),
      .y_o       (cy[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_if.valid) state_d = S_EVAL;
      S_EVAL:   state_d = S_REDUCE;
      S_REDUCE: state_d = S_RESP;
      S_RESP:   if (out_if.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid) begin
      op_q <= in_if.operation;
      px_q <= in_if.point_x;
      py_q <= in_if.point_y;
      qx_q <= in_if.query_x;
    end
    if (state_q == S_EVAL) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
      le_q <= le_d;
    end
    val_q <= val_d;
    st_q  <= st_d;
  end

  always_comb begin
    in_if.ready        = (state_q == S_IDLE);
    out_if.valid       = (state_q == S_RESP);
    out_if.value_y     = val_q;
    out_if.status      = st_q;
    out_if.point_count = CntW'(n_q);
  end

endmodule

>>> tb/sorted_table_nearest_lookup_test.sv
// ----------------------------------------------------------------------------
// Sorted table nearest lookup testbench
// Drives clear, insert, query and unused-code transactions with random idling on both
// channels, predicts each result from an own model of the sorted point table
// and compares every field of every result, in order.
// ----------------------------------------------------------------------------
module sorted_table_nearest_lookup_test;
  import stnl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 256;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value_y;
    logic [2:0]         status;
    logic [8:0]         point_count;
  } lookup_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  stnl_in_if  in_ch ();
  stnl_out_if out_ch ();

  sorted_table_nearest_lookup #(.TABLE_DEPTH(Depth)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  // Predictor state: the sorted table and the limit registers.
  logic signed [31:0] tab_x [Depth];
  logic signed [31:0] tab_y [Depth];
  int unsigned        held;
  logic signed [31:0] lim_xlo, lim_xhi, lim_ylo, lim_yhi;
  logic [3:0]         lim_en;

  item_t   pending_items [$];
  lookup_t expected_lookups [$];
  int      mismatches;
  int      stall_cycles;
  bit      timed_out;
  bit      quiet_phase;
  bit      hold_sender;
  bit      in_fire;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic lookup_t predict_lookup(item_t it);
    lookup_t r;
    int unsigned pos;
    longint dl, dr;
    r = '0;
    r.status = ST_OK;
    case (op_e'(it.operation))
      OP_CLEAR: held = 0;
      OP_INSERT: begin
        pos = 0;
        if ((lim_en[0] && it.point_x < lim_xlo) || (lim_en[1] && it.point_x > lim_xhi) ||
            (lim_en[2] && it.point_y < lim_ylo) || (lim_en[3] && it.point_y > lim_yhi)) begin
          r.status = ST_LIMITS;
        end else begin
          while (pos < held && tab_x[pos] < it.point_x) pos++;
          if (pos < held && tab_x[pos] == it.point_x) begin
            r.status = ST_DUPLICATE;
          end else if (held >= Depth) begin
            r.status = ST_FULL;
          end else begin
            for (int i = held; i > pos; i--) begin
              tab_x[i] = tab_x[i-1];
              tab_y[i] = tab_y[i-1];
            end
            tab_x[pos] = it.point_x;
            tab_y[pos] = it.point_y;
            held++;
            r.status = ST_INSERTED;
          end
        end
      end
      OP_QUERY: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos + 1 < held && tab_x[pos+1] <= it.query_x) pos++;
          if (tab_x[pos] > it.query_x || pos == held - 1) begin
            r.value_y = tab_y[pos];
          end else begin
            dl = longint'(it.query_x) - longint'(tab_x[pos]);
            dr = longint'(tab_x[pos+1]) - longint'(it.query_x);
            r.value_y = (dl < dr) ? tab_y[pos] : tab_y[pos+1];
          end
        end
      end
      default: ;
    endcase
    r.point_count = held[8:0];
    return r;
  endfunction

  // Acceptance is taken at the rising edge and acted on at the next falling one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_fire <= 1'b0;
    else in_fire <= in_ch.valid && in_ch.ready;
  end

  // Driver: items are predicted at acceptance, so the model follows the DUT.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= '0;
      in_ch.point_x <= '0;
      in_ch.point_y <= '0;
      in_ch.query_x <= '0;
    end else begin
      if (in_fire) begin
        expected_lookups.push_back(predict_lookup(pending_items.pop_front()));
      end
      if (!in_ch.valid || in_fire) begin
        if (pending_items.size() > 0 && !hold_sender &&
            (quiet_phase || $urandom_range(99) >= 14)) begin
          in_ch.valid <= 1'b1;
          {in_ch.operation, in_ch.point_x, in_ch.point_y, in_ch.query_x} <=
            pending_items[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet_phase || $urandom_range(99) >= 14;
  end

  // Monitor.
  always @(posedge clk_i) begin
    lookup_t got, want;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.value_y, out_ch.status, out_ch.point_count};
        if (expected_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("sorted_table_nearest_lookup_test NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(40)) - 20;
      3: return ($signed($urandom_range(40)) - 20) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t make_item(op_e op, logic signed [31:0] px,
                                      logic signed [31:0] py, logic signed [31:0] qx);
    item_t it;
    it.operation = op;
    it.point_x = px;
    it.point_y = py;
    it.query_x = qx;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || expected_lookups.size() > 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_X_LOW:  lim_xlo = value;
      REG_X_HIGH: lim_xhi = value;
      REG_Y_LOW:  lim_ylo = value;
      REG_Y_HIGH: lim_yhi = value;
      default:    lim_en = value[3:0];
    endcase
  endtask

  task automatic set_limits(logic [31:0] xlo, logic [31:0] xhi, logic [31:0] ylo,
                            logic [31:0] yhi, logic [3:0] en);
    write_reg(REG_X_LOW, xlo);
    write_reg(REG_X_HIGH, xhi);
    write_reg(REG_Y_LOW, ylo);
    write_reg(REG_Y_HIGH, yhi);
    write_reg(REG_ENABLE, {28'd0, en});
  endtask

  // A phase of random traffic; mostly inserts and queries, whose keys come from the same value mix.
  task automatic random_phase(int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 2) pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0));
      else if (sel < 4) pending_items.push_back(item_t'({2'd3, $urandom, $urandom, $urandom}));
      else if (sel < 50)
        pending_items.push_back(make_item(OP_INSERT, rand_value(), rand_value(), $urandom));
      else pending_items.push_back(make_item(OP_QUERY, $urandom, $urandom, rand_value()));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_X_LOW;
    cfg_data_i = '0;
    held = 0;
    lim_xlo = 32'sh8000_0000;
    lim_xhi = 32'sh7fff_ffff;
    lim_ylo = 32'sh8000_0000;
    lim_yhi = 32'sh7fff_ffff;
    lim_en = '0;
    mismatches = 0;
    stall_cycles = 0;
    timed_out = 1'b0;
    quiet_phase = 1'b0;
    hold_sender = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty query, extremes, duplicate, ties, ends, unused code.
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 5));
    pending_items.push_back(make_item(OP_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 0));
    pending_items.push_back(make_item(OP_INSERT, 32'sh8000_0000, 32'sh7fff_ffff, 0));
    pending_items.push_back(make_item(OP_INSERT, 10, 100, 0));
    pending_items.push_back(make_item(OP_INSERT, 20, 200, 0));
    pending_items.push_back(make_item(OP_INSERT, 10, 999, 0));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 15));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 14));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 10));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 32'sh8000_0000));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 32'sh7fff_ffff));
    pending_items.push_back(item_t'({2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}));
    pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 0));
    pending_items.push_back(make_item(OP_INSERT, 5, 7, 0));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 32'sh8000_0000));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 32'sh7fff_ffff));
    drain();

    // Fill to the top with more inserts than fit, for the full status.
    for (int i = 0; i < Depth + 2; i++)
      pending_items.push_back(make_item(OP_INSERT, (i * 3) - 400, $urandom, 0));
    pending_items.push_back(make_item(OP_INSERT, 5, 1, 0));
    pending_items.push_back(make_item(OP_QUERY, 0, 0, 0));
    pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0));
    drain();

    // Limits at their edges, inclusive.
    set_limits(-5, 5, -7, 7, 4'hf);
    pending_items.push_back(make_item(OP_INSERT, -5, -7, 0));
    pending_items.push_back(make_item(OP_INSERT, 5, 7, 0));
    pending_items.push_back(make_item(OP_INSERT, -6, 0, 0));
    pending_items.push_back(make_item(OP_INSERT, 6, 0, 0));
    pending_items.push_back(make_item(OP_INSERT, 0, -8, 0));
    pending_items.push_back(make_item(OP_INSERT, 0, 8, 0));
    random_phase(200);
    drain();

    set_limits($urandom, $urandom, $urandom, $urandom, 4'($urandom_range(15)));
    random_phase(300);
    drain();

    set_limits(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 4'hf);
    quiet_phase = 1'b1;
    random_phase(300);
    drain();
    quiet_phase = 1'b0;

    set_limits(32'hfff0_0000, 32'h0010_0000, 32'hfff0_0000, 32'h0010_0000, 4'h5);
    random_phase(300);
    drain();

    set_limits(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 4'h0);
    random_phase(150);
    hold_sender = 1'b1;
    while (expected_lookups.size() > 0 || in_ch.valid) @(posedge clk_i);
    hold_sender = 1'b0;
    random_phase(150);
    drain();

    if (mismatches == 0) begin
      $display("sorted_table_nearest_lookup_test OK");
    end else begin
      $display("sorted_table_nearest_lookup_test NOT OK");
    end
    $finish;
  end

endmodule
